/* rtl/bernstein_basis_product_defines.svh */
// assertion macros shared by the bernstein basis product checker
`ifndef BERNSTEIN_BASIS_PRODUCT_DEFINES_SVH
`define BERNSTEIN_BASIS_PRODUCT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bbp_pkg.sv */
// shared constants, types and the binomial table of the bernstein basis product
package bbp_pkg;

  localparam int NUM_DIMS      = 4;
  localparam int MAX_DEGREE    = 15;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W      = 17;
  localparam int CFG_W        = 4;
  localparam int NUM_REGS     = 8;
  localparam int NUM_CFG_DIMS = 4;
  localparam int DIM_IDX_W    = 2;
  localparam int DIM_W        = 3;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int COEF_W       = 13;
  localparam int BINOM_N      = 16;

  localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_LOAD   = 3'd1;
  localparam op_t OP_XPOW   = 3'd2;
  localparam op_t OP_YPOW   = 3'd3;
  localparam op_t OP_MERGE  = 3'd4;
  localparam op_t OP_SCALE  = 3'd5;
  localparam op_t OP_UPDATE = 3'd6;
  localparam op_t OP_EMIT   = 3'd7;

  typedef logic [CFG_W-1:0]  cfg_val_t;
  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    cfg_val_t [NUM_CFG_DIMS-1:0] degree;
    cfg_val_t [NUM_CFG_DIMS-1:0] index;
  } cfg_t;

  typedef struct packed {
    op_t   op;
    coef_t coef;
    logic  bad;
  } cmd_t;

  typedef coef_t [BINOM_N*BINOM_N-1:0] binom_tab_t;

  // pascal triangle, entry {n, j}; entries with j above n stay zero
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n < BINOM_N; n++) begin
      for (int j = 0; j < BINOM_N; j++) begin
        if (j == 0) begin
          t[n*BINOM_N] = coef_t'(1);
        end else if (n > 0) begin
          t[n*BINOM_N+j] = t[(n-1)*BINOM_N+j-1] + t[(n-1)*BINOM_N+j];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

endpackage

/* rtl/bbp_regs.sv */
// apb configuration registers: degree and index of each dimension
module bbp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [bbp_pkg::DATA_W-1:0]   pwdata,
  output logic [bbp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bbp_pkg::cfg_t                cfg_o
);

  bbp_pkg::cfg_val_t [bbp_pkg::NUM_REGS-1:0] reg_q;
  logic [bbp_pkg::ADDR_W-3:0]                reg_idx;
  logic                                      wr_en;

  assign reg_idx = paddr[bbp_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign prdata  = bbp_pkg::DATA_W'(reg_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= '0;
    end else if (wr_en) begin
      reg_q[reg_idx] <= pwdata[bbp_pkg::CFG_W-1:0];
    end
  end

  // even registers hold degrees, odd ones indexes
  always_comb begin
    for (int d = 0; d < bbp_pkg::NUM_CFG_DIMS; d++) begin
      cfg_o.degree[d] = reg_q[2*d];
      cfg_o.index[d]  = reg_q[2*d+1];
    end
  end

endmodule

/* rtl/bbp_ctrl.sv */
// sequencer: walks each coordinate through the power, merge, scale and update steps
module bbp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_coord_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  bbp_pkg::cfg_t cfg_i,
  output bbp_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_XPOW   = 3'd1;
  localparam logic [2:0] S_YPOW   = 3'd2;
  localparam logic [2:0] S_MERGE  = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam int DEG_CMP_W = bbp_pkg::CFG_W + 1;
  localparam logic [bbp_pkg::DIM_W-1:0] DIM_LIMIT = bbp_pkg::DIM_W'(bbp_pkg::NUM_DIMS);
  localparam logic [DEG_CMP_W-1:0]      DEG_LIMIT = DEG_CMP_W'(bbp_pkg::MAX_DEGREE);

  logic [2:0]                 state_q, state_d;
  bbp_pkg::cfg_val_t          cnt_q, cnt_d;
  bbp_pkg::cfg_val_t          rem_q, rem_d;
  bbp_pkg::cfg_val_t          deg_q, deg_d;
  bbp_pkg::cfg_val_t          idx_q, idx_d;
  logic                       last_q, last_d;
  logic [bbp_pkg::DIM_W-1:0]  dim_q, dim_d;
  logic                       err_q, err_d;
  logic                       out_valid_q, out_valid_d;

  bbp_pkg::cfg_val_t n_cur, j_cur;
  logic              over_dims, bad_cfg, out_free;

  assign n_cur     = cfg_i.degree[dim_q[bbp_pkg::DIM_IDX_W-1:0]];
  assign j_cur     = cfg_i.index[dim_q[bbp_pkg::DIM_IDX_W-1:0]];
  assign over_dims = dim_q >= DIM_LIMIT;
  assign bad_cfg   = (j_cur > n_cur) || ({1'b0, n_cur} > DEG_LIMIT);
  assign out_free  = ~out_valid_q | ~out_stall_i;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    deg_d       = deg_q;
    idx_d       = idx_q;
    last_d      = last_q;
    dim_d       = dim_q;
    err_d       = err_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o.op    = bbp_pkg::OP_NONE;
    cmd_o.coef  = bbp_pkg::BINOM[{deg_q, idx_q}];
    cmd_o.bad   = err_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_coord_i;
          if (over_dims) begin
            err_d   = 1'b1;
            state_d = last_coord_i ? S_DONE : S_IDLE;
          end else begin
            dim_d = dim_q + 1'b1;
            if (bad_cfg) begin
              // flagged coordinate leaves the product alone
              err_d   = 1'b1;
              state_d = last_coord_i ? S_DONE : S_IDLE;
            end else begin
              cmd_o.op = bbp_pkg::OP_LOAD;
              cnt_d    = j_cur;
              rem_d    = n_cur - j_cur;
              deg_d    = n_cur;
              idx_d    = j_cur;
              state_d  = S_XPOW;
            end
          end
        end
      end
      S_XPOW: begin
        if (cnt_q == '0) begin
          state_d = S_YPOW;
        end else begin
          cmd_o.op = bbp_pkg::OP_XPOW;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      S_YPOW: begin
        if (rem_q == '0) begin
          state_d = S_MERGE;
        end else begin
          cmd_o.op = bbp_pkg::OP_YPOW;
          rem_d    = rem_q - 1'b1;
        end
      end
      S_MERGE: begin
        cmd_o.op = bbp_pkg::OP_MERGE;
        state_d  = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = bbp_pkg::OP_SCALE;
        state_d  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.op = bbp_pkg::OP_UPDATE;
        state_d  = last_q ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        // wait for the output register, then start a fresh point
        if (out_free) begin
          cmd_o.op    = bbp_pkg::OP_EMIT;
          out_valid_d = 1'b1;
          dim_d       = '0;
          err_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      deg_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      dim_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      deg_q       <= deg_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      dim_q       <= dim_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/bbp_dp.sv */
// datapath: one shared fixed-point multiplier with power, term and product registers
module bbp_dp #(
  parameter int FRAC_BITS = bbp_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bbp_pkg::COORD_W-1:0]  coordinate_i,
  input  bbp_pkg::cmd_t                cmd_i,
  output logic [bbp_pkg::COORD_W-1:0]  basis_value_o,
  output logic                         bad_setting_o
);

  localparam int VW  = FRAC_BITS + 1;
  localparam int MW  = (VW > bbp_pkg::COEF_W) ? VW : bbp_pkg::COEF_W;
  localparam int PW  = 2 * MW;
  localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int XW  = bbp_pkg::COORD_W + SHR;
  localparam int OW  = VW + SHL;

  localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [VW-1:0]               x_q, xp_q, yp_q, prod_q;
  logic [bbp_pkg::COORD_W-1:0] out_val_q;
  logic                        out_bad_q;

  logic [bbp_pkg::COORD_W-1:0] coord_sat, out_in;
  logic [VW-1:0]               x_in, shifted, sat;
  logic [MW-1:0]               op_a, op_b;
  logic [PW-1:0]               mul;

  assign coord_sat = (coordinate_i > bbp_pkg::COORD_ONE) ? bbp_pkg::COORD_ONE : coordinate_i;
  assign x_in      = VW'((XW'(coord_sat) << SHR) >> SHL);
  assign out_in    = bbp_pkg::COORD_W'((OW'(prod_q) >> SHR) << SHL);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.op)
      bbp_pkg::OP_XPOW: begin
        op_a = MW'(xp_q);
        op_b = MW'(x_q);
      end
      bbp_pkg::OP_YPOW: begin
        op_a = MW'(yp_q);
        op_b = MW'(ONE - x_q);
      end
      bbp_pkg::OP_MERGE: begin
        op_a = MW'(xp_q);
        op_b = MW'(yp_q);
      end
      bbp_pkg::OP_SCALE: begin
        op_a = MW'(xp_q);
        op_b = MW'(cmd_i.coef);
      end
      bbp_pkg::OP_UPDATE: begin
        op_a = MW'(prod_q);
        op_b = MW'(xp_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul     = PW'(op_a) * PW'(op_b);
  assign shifted = VW'(mul >> FRAC_BITS);
  // binomial scaling is not renormalized, only clipped at one
  assign sat     = (mul > PW'(ONE)) ? ONE : VW'(mul);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bbp_pkg::OP_LOAD: begin
        x_q  <= x_in;
        xp_q <= ONE;
        yp_q <= ONE;
      end
      bbp_pkg::OP_XPOW:  xp_q <= shifted;
      bbp_pkg::OP_YPOW:  yp_q <= shifted;
      bbp_pkg::OP_MERGE: xp_q <= shifted;
      bbp_pkg::OP_SCALE: xp_q <= sat;
      bbp_pkg::OP_EMIT: begin
        out_val_q <= cmd_i.bad ? '0 : out_in;
        out_bad_q <= cmd_i.bad;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= ONE;
    end else begin
      case (cmd_i.op)
        bbp_pkg::OP_UPDATE: prod_q <= shifted;
        bbp_pkg::OP_EMIT:   prod_q <= ONE;
        default: ;
      endcase
    end
  end

  assign basis_value_o = out_val_q;
  assign bad_setting_o = out_bad_q;

endmodule

/* rtl/bernstein_basis_product.sv */
// Tensor-product Bernstein basis evaluator. Each transaction on the input brings one coordinate
// (unsigned Q1.16, saturated at 1.0); the coordinate of dimension d contributes
// C(n,j) * x^j * (1-x)^(n-j) with n and j from that dimension's registers, and the transaction
// marked last_coord ends the point and yields one result transaction with the truncated Q1.16
// product, or zero with bad_setting set when an index exceeded its degree, a degree exceeded
// the supported maximum or more than four coordinates arrived. All arithmetic runs on a single
// shared multiplier, so one item at a time is in flight: a valid coordinate runs a load, j steps
// for x^j, n - j steps for (1-x)^(n-j), two loop exits, a merge, a binomial scale and a product
// update; a flagged coordinate skips these steps; the last coordinate of a point adds a step that
// moves the result into the output register, waiting there while a stalled result is held.
// A waiting result does not block the next coordinate. Registers are written over
// the APB port at byte address 4*i in the order degree0, index0, ... degree3, index3.
module bernstein_basis_product #(
  parameter int FRAC_BITS = bbp_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bbp_pkg::COORD_W-1:0]  coordinate_i,
  input  logic                         last_coord_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bbp_pkg::COORD_W-1:0]  basis_value_o,
  output logic                         bad_setting_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [bbp_pkg::DATA_W-1:0]   pwdata,
  output logic [bbp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  bbp_pkg::cfg_t cfg;
  bbp_pkg::cmd_t cmd;

  bbp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_coord_i (last_coord_i),
    .in_stall_o   (in_stall_o),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cfg_i        (cfg),
    .cmd_o        (cmd)
  );

  bbp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coordinate_i  (coordinate_i),
    .cmd_i         (cmd),
    .basis_value_o (basis_value_o),
    .bad_setting_o (bad_setting_o)
  );

endmodule

/* rtl/bbp_checker.sv */
// port-level checks on the bernstein basis product, bound to the top level
`include "bernstein_basis_product_defines.svh"

module bbp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [bbp_pkg::COORD_W-1:0]  basis_value_o,
  input logic                         bad_setting_o
);

  // a stalled result keeps its valid and payload
  `BBP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(basis_value_o) && $stable(bad_setting_o), "stalled result changed")

  // a flagged point always reads as zero
  `BBP_ASSERT_NOW(a_bad_zero, out_valid_o && bad_setting_o, basis_value_o == '0, "flagged result is not zero")

  // a product of terms clipped at one never exceeds one
  `BBP_ASSERT_NOW(a_value_range, out_valid_o && !bad_setting_o, basis_value_o <= bbp_pkg::COORD_ONE, "result above one")

  // a new result only appears from the busy finishing step
  `BBP_ASSERT_NOW(a_emit_busy, $rose(out_valid_o), $past(in_stall_o), "result appeared while input was open")

endmodule

bind bernstein_basis_product bbp_checker u_checker (.*);
